>>> hw/rtl/dsep_pkg.sv
`timescale 1ns / 1ps
// dsep_pkg: shared types and constants of the date string parser

package dsep_pkg;

   localparam int NumMax = 9999;

   // fields handed from the tokenizer to the epoch conversion
   typedef struct packed {
      logic [13:0]        year;
      logic [3:0]         month;
      logic [13:0]        day;
      logic [13:0]        hour;
      logic [13:0]        minute;
      logic [13:0]        second;
      logic               gmt;
      logic signed [15:0] zone;
   } fields_type;

   // offset scan phases after the zone token
   typedef enum logic [1:0] {
      ZONE_IDLE  = 2'd0,
      ZONE_LEAD  = 2'd1,
      ZONE_SIGN  = 2'd2,
      ZONE_DIGIT = 2'd3
   } zone_phase_type;

   // month name match on the upper-cased token head, 12 when none
   function automatic logic [3:0] month_code(input logic [23:0] head);
      logic [3:0] r;
      r = 4'd12;
      unique case (head)
         {"N", "A", "J"}: r = 4'd0;
         {"B", "E", "F"}: r = 4'd1;
         {"R", "A", "M"}: r = 4'd2;
         {"R", "P", "A"}: r = 4'd3;
         {"Y", "A", "M"}: r = 4'd4;
         {"N", "U", "J"}: r = 4'd5;
         {"L", "U", "J"}: r = 4'd6;
         {"G", "U", "A"}: r = 4'd7;
         {"P", "E", "S"}: r = 4'd8;
         {"T", "C", "O"}: r = 4'd9;
         {"V", "O", "N"}: r = 4'd10;
         {"C", "E", "D"}: r = 4'd11;
         default: r = 4'd12;
      endcase
      return r;
   endfunction

   // days before the month, year starting in march (month 0 to 11 = jan to dec)
   function automatic logic [8:0] month_days(input logic [3:0] m);
      logic [8:0] r;
      unique case (m)
         4'd0:  r = 9'd306;
         4'd1:  r = 9'd337;
         4'd2:  r = 9'd0;
         4'd3:  r = 9'd31;
         4'd4:  r = 9'd61;
         4'd5:  r = 9'd92;
         4'd6:  r = 9'd122;
         4'd7:  r = 9'd153;
         4'd8:  r = 9'd184;
         4'd9:  r = 9'd214;
         4'd10: r = 9'd245;
         4'd11: r = 9'd275;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/dsep_front.sv
`timescale 1ns / 1ps
// dsep_front: tokenizer and field capture, one byte per cycle unless the output word is held

module dsep_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_is_last,
   output logic                   fq_valid,
   input  logic                   fq_ready,
   output dsep_pkg::fields_type   fq_fields
);

   logic [23:0] head_ff, head_in;
   logic [4:0]  len_ff, len_in;
   logic [13:0] num_ff, num_in;
   logic        lead_ff, lead_in;
   logic        open_ff, open_in;
   logic [1:0]  slot_ff, slot_in;
   logic [13:0] day_ff, day_in, mon_unused;
   logic [3:0]  mon_ff, mon_in;
   logic [13:0] year_ff, year_in, hour_ff, hour_in, min_ff, min_in, sec_ff, sec_in;
   logic        dtaken_ff, dtaken_in, gmt_ff, gmt_in;
   logic [13:0] zmag_ff, zmag_in;
   logic        zneg_ff, zneg_in;
   dsep_pkg::zone_phase_type zph_ff, zph_in;

   logic       fire, alnum, digit, lower, do_finish;
   logic [7:0] c, u;
   logic [7:0] term;
   logic       term_valid;
   logic [3:0] dv;
   logic [17:0] nx;
   logic [13:0] val;
   logic [3:0] mcode;

   assign mon_unused = '0;
   assign req_ready = !fq_valid || fq_ready;
   assign fire = req_valid && req_ready;
   assign c = req_text_byte;
   assign digit = (c >= "0") && (c <= "9");
   assign lower = (c >= "a") && (c <= "z");
   assign alnum = digit || lower || ((c >= "A") && (c <= "Z"));
   assign u = lower ? c - 8'd32 : c;
   assign dv = c[3:0];

   // offset digit accumulation, saturating
   function automatic logic [13:0] acc(input logic [13:0] m, input logic [3:0] d);
      logic [17:0] t;
      t = {m, 3'b000} + {3'b000, m, 1'b0} + {14'd0, d};
      return (t > 18'(dsep_pkg::NumMax)) ? 14'(dsep_pkg::NumMax) : t[13:0];
   endfunction

   always_comb begin
      head_in = head_ff; len_in = len_ff; num_in = num_ff; lead_in = lead_ff;
      open_in = open_ff; slot_in = slot_ff; day_in = day_ff; mon_in = mon_ff;
      year_in = year_ff; hour_in = hour_ff; min_in = min_ff; sec_in = sec_ff;
      dtaken_in = dtaken_ff; gmt_in = gmt_ff; zmag_in = zmag_ff; zneg_in = zneg_ff;
      zph_in = zph_ff;
      do_finish = 1'b0; term = c; term_valid = 1'b1;
      nx = '0; val = '0; mcode = 4'd12;
      if (gmt_ff) begin
         if (zph_ff != dsep_pkg::ZONE_IDLE) begin
            if (zph_ff == dsep_pkg::ZONE_LEAD && (c == " " || (c >= 8'd9 && c <= 8'd13))) begin
            end else if (zph_ff == dsep_pkg::ZONE_LEAD && (c == "+" || c == "-")) begin
               zneg_in = (c == "-"); zph_in = dsep_pkg::ZONE_SIGN;
            end else if (digit) begin
               zmag_in = acc(zmag_ff, dv); zph_in = dsep_pkg::ZONE_DIGIT;
            end else begin
               zph_in = dsep_pkg::ZONE_IDLE;
            end
         end
      end else if (alnum) begin
         if (len_ff == 5'd0) begin
            lead_in = digit; open_in = digit;
         end
         if (len_ff == 5'd0) head_in[7:0] = u;
         if (len_ff == 5'd1) head_in[15:8] = u;
         if (len_ff == 5'd2) head_in[23:16] = u;
         if (len_ff != 5'd31) len_in = len_ff + 5'd1;
         if (open_in && digit) begin
            nx = {num_ff, 3'b000} + {3'b000, num_ff, 1'b0} + {14'd0, dv};
            num_in = (nx > 18'(dsep_pkg::NumMax)) ? 14'(dsep_pkg::NumMax) : nx[13:0];
         end else begin
            open_in = 1'b0;
         end
         if (req_is_last) begin
            do_finish = 1'b1; term_valid = 1'b0;
         end
      end else if (len_ff != 5'd0) begin
         do_finish = 1'b1;
      end

      if (do_finish) begin
         val = lead_in ? num_in : 14'd0;
         // month lookup on the head, including this byte when it is alphanumeric
         mcode = dsep_pkg::month_code(head_in);
         if (slot_ff == 2'd1) begin
            min_in = val; slot_in = 2'd2;
         end else if (slot_ff == 2'd2) begin
            sec_in = val; slot_in = 2'd0;
         end else if (len_in >= 5'd3 && mcode != 4'd12) begin
            mon_in = mcode;
         end else if (term_valid && term == ":") begin
            hour_in = val; slot_in = 2'd1;
         end else if (lead_in) begin
            if (!dtaken_ff) begin
               day_in = val; dtaken_in = 1'b1;
            end else if (val < 14'd70) begin
               year_in = val + 14'd2000;
            end else if (val < 14'd1970) begin
               year_in = val + 14'd1900;
            end else begin
               year_in = val;
            end
         end else if (len_in == 5'd3 && head_in == {"T", "M", "G"}) begin
            gmt_in = 1'b1; zph_in = dsep_pkg::ZONE_LEAD;
            if (term_valid) begin
               if (c == "+" || c == "-") begin
                  zneg_in = (c == "-"); zph_in = dsep_pkg::ZONE_SIGN;
               end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                  zph_in = dsep_pkg::ZONE_IDLE;
               end
            end
         end
         head_in = '0; len_in = '0; num_in = '0; lead_in = 1'b0; open_in = 1'b0;
      end

      if (req_is_last) begin
         if (slot_in == 2'd1) begin
            min_in = '0; sec_in = '0;
         end else if (slot_in == 2'd2) begin
            sec_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && req_is_last)) begin
         head_ff <= '0; len_ff <= '0; num_ff <= '0; lead_ff <= 1'b0; open_ff <= 1'b0;
         slot_ff <= '0; day_ff <= '0; mon_ff <= '0; year_ff <= 14'd1900;
         hour_ff <= '0; min_ff <= '0; sec_ff <= '0; dtaken_ff <= 1'b0; gmt_ff <= 1'b0;
         zmag_ff <= '0; zneg_ff <= 1'b0; zph_ff <= dsep_pkg::ZONE_IDLE;
      end else if (fire) begin
         head_ff <= head_in; len_ff <= len_in; num_ff <= num_in; lead_ff <= lead_in;
         open_ff <= open_in; slot_ff <= slot_in; day_ff <= day_in + mon_unused;
         mon_ff <= mon_in; year_ff <= year_in; hour_ff <= hour_in; min_ff <= min_in;
         sec_ff <= sec_in; dtaken_ff <= dtaken_in; gmt_ff <= gmt_in;
         zmag_ff <= zmag_in; zneg_ff <= zneg_in; zph_ff <= zph_in;
      end
   end

   // output word register toward the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         fq_valid <= 1'b0;
      end else if (fire && req_is_last) begin
         fq_valid <= 1'b1;
      end else if (fq_ready) begin
         fq_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req_is_last) begin
         fq_fields.year   <= year_in;
         fq_fields.month  <= mon_in;
         fq_fields.day    <= day_in;
         fq_fields.hour   <= hour_in;
         fq_fields.minute <= min_in;
         fq_fields.second <= sec_in;
         fq_fields.gmt    <= gmt_in;
         fq_fields.zone   <= zneg_in ? -$signed({2'b00, zmag_in}) : $signed({2'b00, zmag_in});
      end
   end

   a_len_sat: assert property (@(posedge clock) disable iff (reset) len_ff <= 5'd31)
      else $error("token length overflow");
   a_num_sat: assert property (@(posedge clock) disable iff (reset)
      num_ff <= 14'(dsep_pkg::NumMax)) else $error("number not saturated");
   a_zone_sat: assert property (@(posedge clock) disable iff (reset)
      zmag_ff <= 14'(dsep_pkg::NumMax)) else $error("offset not saturated");
   a_gmt_tok: assert property (@(posedge clock) disable iff (reset)
      gmt_ff |-> len_ff == 5'd0) else $error("token open after zone");

endmodule

>>> hw/rtl/dsep_back.sv
`timescale 1ns / 1ps
// dsep_back: pipelined conversion of date fields to epoch milliseconds

module dsep_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [11:0]          local_min,
   input  logic                        fq_valid,
   output logic                        fq_ready,
   input  dsep_pkg::fields_type        fq_fields,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [48:0]          rsp_epoch_millis
);

   // stage valids; the pipeline stalls as a whole
   logic [3:0] v_ff;
   logic       adv;
   assign adv = !rsp_valid || rsp_ready;
   assign fq_ready = adv;
   assign rsp_valid = v_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], fq_valid};
      end
   end

   // stage 1: year split into era, day of year, time of day, zone hours and minutes
   logic signed [15:0] y1;
   logic signed [15:0] era_c;
   logic [8:0]  yoe_c;
   logic signed [15:0] era_ff;
   logic [8:0]  yoe_ff;
   logic [8:0]  doy_ff;
   logic [13:0] day_ff;
   logic signed [31:0] tod_ff;
   logic [28:0] q400;
   logic [13:0] zabs;
   logic [25:0] zprod;
   logic [6:0]  zq_c, zr_c;
   logic [6:0]  zq_ff, zr_ff;
   logic        zneg_ff;
   logic        loc_on;
   assign y1 = $signed({2'b00, fq_fields.year}) - ((fq_fields.month <= 4'd1) ? 16'sd1 : 16'sd0);
   // y in 1899..9999, floor divide by 400 via reciprocal
   assign q400 = 29'(y1[13:0]) * 29'd20972 >> 23;
   always_comb begin
      if (y1 < 0) begin
         era_c = -16'sd1; yoe_c = 9'd399;
      end else begin
         era_c = $signed({2'b00, q400[13:0]});
         yoe_c = 9'(y1[13:0] - 14'(q400[13:0] * 14'd400));
      end
   end

   // zone magnitude hhmm split by reciprocal of 100, exact up to 9999
   assign zabs = fq_fields.zone[15] ? 14'(-fq_fields.zone) : fq_fields.zone[13:0];
   assign zprod = 26'(zabs) * 26'd5243;
   assign zq_c = 7'(zprod >> 19);
   assign zr_c = 7'(zabs - 14'(zq_c) * 14'd100);
   assign loc_on = (fq_fields.zone == 16'sd0) && !fq_fields.gmt;

   always_ff @(posedge clock) begin
      if (adv) begin
         era_ff <= era_c;
         yoe_ff <= yoe_c;
         doy_ff <= dsep_pkg::month_days(fq_fields.month);
         day_ff <= fq_fields.day;
         tod_ff <= 32'(fq_fields.hour) * 32'sd3600 + 32'(fq_fields.minute) * 32'sd60
                   + 32'(fq_fields.second)
                   + (loc_on ? 32'(local_min) * 32'sd60 : 32'sd0);
         zq_ff <= zq_c;
         zr_ff <= zr_c;
         zneg_ff <= fq_fields.zone[15];
      end
   end

   // stage 2: day count, zone applied to time of day
   logic signed [31:0] days_ff, tod2_ff;
   logic [7:0] yoe100;
   logic signed [31:0] zsec;
   assign yoe100 = 8'((18'(yoe_ff) * 18'd41) >> 12);
   assign zsec = 32'(zq_ff) * 32'sd3600 + 32'(zr_ff) * 32'sd60;
   always_ff @(posedge clock) begin
      if (adv) begin
         days_ff <= 32'(era_ff) * 32'sd146097 + 32'(yoe_ff) * 32'sd365
                    + 32'(yoe_ff >> 2) - 32'(yoe100) + 32'(doy_ff)
                    - 32'sd719468 + 32'(day_ff) - 32'sd1;
         tod2_ff <= zneg_ff ? tod_ff + zsec : tod_ff - zsec;
      end
   end

   // stage 3: seconds
   logic signed [47:0] secs_ff;
   always_ff @(posedge clock) begin
      if (adv) secs_ff <= 48'(days_ff) * 48'sd86400 + 48'(tod2_ff);
   end

   // stage 4: milliseconds
   always_ff @(posedge clock) begin
      if (adv) rsp_epoch_millis <= 49'(secs_ff) * 49'sd1000;
   end

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_epoch_millis))
      else $error("result lost on stall");
   a_ready: assert property (@(posedge clock) disable iff (reset) fq_ready == adv)
      else $error("queue ready mismatch");
   a_yoe: assert property (@(posedge clock) disable iff (reset) v_ff[0] |-> yoe_ff < 9'd400)
      else $error("year of era out of range");

endmodule

>>> hw/rtl/date_string_to_epoch_parser.sv
`timescale 1ns / 1ps
// date_string_to_epoch_parser: top level of the date text parser
// takes one text byte per cycle, one word per cycle sustained, while the
// conversion pipeline does not stall; the front tokenizer captures fields, a
// one-word register hands them to a four-stage conversion pipeline, and the
// next string may start in the very next cycle unless that pipeline stalls

module date_string_to_epoch_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [48:0] rsp_epoch_millis,
   input  logic               csr_write_enable,
   input  logic [11:0]        csr_write_data
);

   // local offset register
   logic signed [11:0] local_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff <= '0;
      end else if (csr_write_enable) begin
         local_ff <= $signed(csr_write_data);
      end
   end

   logic                 fq_valid, fq_ready;
   dsep_pkg::fields_type fq_fields;

   dsep_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_text_byte, .req_is_last,
      .fq_valid, .fq_ready, .fq_fields
   );

   dsep_back u_back (
      .clock, .reset, .local_min(local_ff), .fq_valid, .fq_ready, .fq_fields,
      .rsp_valid, .rsp_ready, .rsp_epoch_millis
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench of the date string parser, strings fed byte by byte

module tb;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_text_byte;
   logic               req_is_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [48:0] rsp_epoch_millis;
   logic               csr_write_enable;
   logic [11:0]        csr_write_data;

   date_string_to_epoch_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_epoch_millis (rsp_epoch_millis),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // one pending word of the input channel
   typedef struct {
      logic [7:0] text;
      logic       last;
   } byte_word_type;

   // a directed string, with a hand-read answer where it is obvious
   typedef struct {
      string       text;
      bit          has_answer;
      longint      answer;
   } date_row_type;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor state: a private copy of the tokenizer and the register
   // ---------------------------------------------------------------------
   int             p_local_minutes;
   logic [7:0]     p_head [3];
   int             p_len;
   int             p_num;
   bit             p_leads_digit;
   bit             p_digits_open;
   int             p_slot;
   int             p_day, p_month, p_year, p_hour, p_minute, p_second;
   bit             p_day_taken;
   bit             p_gmt;
   int             p_zone;
   dsep_pkg::zone_phase_type p_zphase;
   bit             p_zneg;

   // expected millis, oldest first
   longint         millis_due [$];
   // hand-typed answers checked against the predictor for directed rows
   bit             override_q [$];
   longint         override_val [$];

   bit             failed;
   int unsigned    cycle_count;
   int             sender_idle_pct;
   int             receiver_idle_pct;
   bit             hold_off;
   int             hold_left;

   function automatic void clear_token();
      p_head = '{8'd0, 8'd0, 8'd0};
      p_len = 0; p_num = 0; p_leads_digit = 0; p_digits_open = 0;
   endfunction

   function automatic void clear_parse();
      clear_token();
      p_slot = 0; p_day = 0; p_month = 0; p_year = 1900;
      p_hour = 0; p_minute = 0; p_second = 0;
      p_day_taken = 0; p_gmt = 0; p_zone = 0; p_zphase = dsep_pkg::ZONE_IDLE; p_zneg = 0;
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alnum(logic [7:0] c);
      return is_num(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   // month index of the token head, or -1
   function automatic int month_of_head();
      string names;
      names = "JANFEBMARAPRMAYJUNJULAUGSEPOCTNOVDEC";
      for (int i = 0; i < 12; i++)
         if (p_head[0] == names[3*i] && p_head[1] == names[3*i+1] &&
             p_head[2] == names[3*i+2])
            return i;
      return -1;
   endfunction

   function automatic void zone_scan(logic [7:0] c);
      int mag;
      if (p_zphase == dsep_pkg::ZONE_LEAD && (c == " " || (c >= 9 && c <= 13))) return;
      if (p_zphase == dsep_pkg::ZONE_LEAD && (c == "+" || c == "-")) begin
         p_zneg = (c == "-");
         p_zphase = dsep_pkg::ZONE_SIGN;
         return;
      end
      if (p_zphase != dsep_pkg::ZONE_IDLE && is_num(c)) begin
         mag = p_zone < 0 ? -p_zone : p_zone;
         mag = mag * 10 + (c - "0");
         if (mag > dsep_pkg::NumMax) mag = dsep_pkg::NumMax;
         p_zone = p_zneg ? -mag : mag;
         p_zphase = dsep_pkg::ZONE_DIGIT;
         return;
      end
      p_zphase = dsep_pkg::ZONE_IDLE;
   endfunction

   // term > 255 means end of string
   function automatic void close_token(int term);
      int val;
      int m;
      val = p_leads_digit ? p_num : 0;
      if (p_slot == 1) begin
         p_minute = val; p_slot = 2; clear_token(); return;
      end
      if (p_slot == 2) begin
         p_second = val; p_slot = 0; clear_token(); return;
      end
      if (p_len >= 3) begin
         m = month_of_head();
         if (m >= 0) begin
            p_month = m; clear_token(); return;
         end
      end
      if (term == ":") begin
         p_hour = val; p_slot = 1;
      end else if (p_leads_digit) begin
         if (!p_day_taken) begin
            p_day = val; p_day_taken = 1;
         end else if (val < 70) p_year = val + 2000;
         else if (val < 1970) p_year = val + 1900;
         else p_year = val;
      end else if (p_len == 3 && p_head[0] == "G" && p_head[1] == "M" &&
                   p_head[2] == "T") begin
         p_gmt = 1;
         p_zphase = dsep_pkg::ZONE_LEAD;
         if (term < 256) zone_scan(term[7:0]);
      end
      clear_token();
   endfunction

   // proleptic gregorian day number relative to 1970-01-01
   function automatic longint days_from_epoch(longint y, longint m);
      longint era, yoe, doy, doe;
      if (m <= 2) y -= 1;
      era = y / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // advance the parse by one accepted word; queue millis on the last byte
   function automatic void parse_byte(logic [7:0] c, logic last);
      logic [7:0] u;
      longint secs;
      logic [48:0] ms;
      if (p_gmt) begin
         if (p_zphase != dsep_pkg::ZONE_IDLE) zone_scan(c);
      end else if (is_alnum(c)) begin
         u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
         if (p_len == 0) begin
            p_leads_digit = is_num(c);
            p_digits_open = p_leads_digit;
         end
         if (p_len < 3) p_head[p_len] = u;
         if (p_len < 31) p_len++;
         if (p_digits_open && is_num(c)) begin
            p_num = p_num * 10 + (c - "0");
            if (p_num > dsep_pkg::NumMax) p_num = dsep_pkg::NumMax;
         end else p_digits_open = 0;
         if (last) close_token(256);
      end else if (p_len > 0) close_token(c);
      if (!last) return;
      if (p_slot == 1) begin
         p_minute = 0; p_second = 0;
      end else if (p_slot == 2) p_second = 0;
      secs = (days_from_epoch(p_year, p_month + 1) + p_day - 1) * 86400
           + longint'(p_hour) * 3600 + p_minute * 60 + p_second;
      if (p_zone != 0) begin
         secs -= 3600 * longint'(p_zone / 100);
         secs -= 60 * longint'(p_zone % 100);
      end else if (!p_gmt) secs += longint'(p_local_minutes) * 60;
      ms = 49'(secs * 1000);
      millis_due.push_back(longint'($signed(ms)));
      clear_parse();
   endfunction

   // ---------------------------------------------------------------------
   // sender: words go onto a queue, driven at the falling edge
   // ---------------------------------------------------------------------
   byte_word_type word_q [$];
   bit req_ready_seen;

   task automatic push_string(string s);
      byte_word_type w;
      for (int i = 0; i < s.len(); i++) begin
         w.text = s[i];
         w.last = (i == s.len() - 1);
         word_q.push_back(w);
      end
   endtask

   // waits for the queue to drain through the handshake
   task automatic drain_input();
      while (word_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready_seen) begin
         // previous word taken or none offered
         if (word_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid     <= 1'b1;
            req_text_byte <= word_q[0].text;
            req_is_last   <= word_q[0].last;
            void'(word_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // handshake seen at the rising edge; the predictor runs here
   always @(posedge clock) begin
      req_ready_seen <= 1'b0;
      if (!reset && req_valid && req_ready) begin
         req_ready_seen <= 1'b1;
         parse_byte(req_text_byte, req_is_last);
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random ready at the falling edge, long counted hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
         hold_left <= 300;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      longint want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (millis_due.size() == 0) begin
            $error("epoch_millis: unexpected word, actual %0d", rsp_epoch_millis);
            failed = 1;
         end else begin
            want = millis_due.pop_front();
            // directed rows with a typed answer are checked against it too
            if (override_q.size() != 0) begin
               if (override_q[0] && override_val[0] != want) begin
                  $error("epoch_millis: table %0d, predictor %0d", override_val[0], want);
                  failed = 1;
               end
               void'(override_q.pop_front());
               void'(override_val.pop_front());
            end
            if (longint'(rsp_epoch_millis) != want) begin
               $error("epoch_millis: expected %0d, actual %0d", want, rsp_epoch_millis);
               failed = 1;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("date_string_to_epoch_parser test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // random string pieces
   // ---------------------------------------------------------------------
   function automatic string pick_month();
      string names [12] = '{"Jan", "feb", "MAR", "Apr", "may", "June", "Jul", "AUGUST",
                            "Sep", "oct", "Nov", "December"};
      return names[$urandom_range(11)];
   endfunction

   function automatic string num_text(int v);
      return $sformatf("%0d", v);
   endfunction

   function automatic string noise_text(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(1, 255)))};
      return s;
   endfunction

   // mostly well-formed dates with random content, some broken ones
   function automatic string random_date();
      string s;
      int kind;
      kind = $urandom_range(99);
      if (kind < 8) return noise_text($urandom_range(1, 12));
      s = ($urandom_range(1)) ? "Sun, " : "";
      if (kind < 14) s = {s, "junk "};
      s = {s, num_text($urandom_range(0, 31)), " ", pick_month(), " "};
      case ($urandom_range(3))
         0: s = {s, num_text($urandom_range(0, 69))};
         1: s = {s, num_text($urandom_range(70, 1969))};
         2: s = {s, num_text($urandom_range(1970, 9999))};
         default: s = {s, num_text($urandom_range(0, 99999))};
      endcase
      s = {s, " ", num_text($urandom_range(0, 30)), ":", num_text($urandom_range(0, 70))};
      if ($urandom_range(3) != 0) s = {s, ":", num_text($urandom_range(0, 70))};
      if (kind < 20) s = {s, ":"};
      case ($urandom_range(3))
         0: ;
         1: s = {s, " GMT"};
         2: s = {s, " gmt ", string'($urandom_range(1) ? "+" : "-"),
                 num_text($urandom_range(0, 99999))};
         default: s = {s, " GMT", noise_text($urandom_range(1, 4))};
      endcase
      if (kind < 30) s = {s, noise_text($urandom_range(1, 3))};
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------------
   date_row_type table_rows [$];

   task automatic run_rows();
      foreach (table_rows[i]) begin
         push_string(table_rows[i].text);
         override_q.push_back(table_rows[i].has_answer);
         override_val.push_back(table_rows[i].answer);
      end
   endtask

   task automatic wait_results();
      drain_input();
      while (millis_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_local(int minutes);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= 12'(minutes);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      p_local_minutes = minutes;
   endtask

   initial begin
      int sent;
      string s;
      failed = 0;
      cycle_count = 0;
      hold_off = 0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      req_valid = 0;
      req_text_byte = 0;
      req_is_last = 0;
      rsp_ready = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      req_ready_seen = 0;
      p_local_minutes = 0;
      clear_parse();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed strings; typed answers where they read off directly
      table_rows = '{
         '{".", 1, -64'sd2208988800000 - 64'sd86400000},   // empty: 1900-01-00
         '{"1 Jan 1970 00:00:00 GMT", 1, 0},
         '{"Thu, 01 JAN 70 00:00:01 gmt", 1, 1000},
         '{"9999 dec 9999 99:99:99 GMT", 0, 0},
         '{"99999999 sep 12345678", 0, 0},
         '{"1 Jan 1970 00:00:00 GMT +0130", 1, -5400000},
         '{"1 Jan 1970 00:00:00 GMT -99999", 0, 0},
         '{"1 Jan 1970 00:00:00 GMT+", 1, 0},
         '{"1 Jan 1970 00:00:00 GMT \t -0015 junk", 1, 900000},
         '{"1 Jan 1970 00:00:00 GMTX", 0, 0},
         '{"2 feb 69 10:", 0, 0},
         '{"2 feb 1969 10:30", 0, 0},
         '{"x:y:z 3 mar 1999", 0, 0},
         '{"Mon\x80\xff7\x01april\x7f2004 a1:2b:c3", 0, 0},
         '{"5 may 0 ::: ", 0, 0},
         '{"Jun 6 1900 12:00:00 PST", 0, 0},
         '{"jul 7 2000 ab cd", 0, 0},
         '{"Aug 8 8 OCT 31 NOV 29 DEC", 0, 0},
         '{"000001 Mar 2000 23:59:59 GMT", 0, 0},
         '{"Z", 0, 0}
      };
      run_rows();
      wait_results();

      // register extremes with local time strings
      write_local(1440);
      push_string("1 Jan 1970 00:00:00"); override_q.push_back(1);
      override_val.push_back(86400000);
      wait_results();
      write_local(-1440);
      write_local(-2048);
      push_string("1 Jan 1970 00:00:00"); override_q.push_back(1);
      override_val.push_back(-122880000);
      wait_results();
      write_local(2047);
      push_string("1 Jan 1970 00:00:00 GMT"); override_q.push_back(1);
      override_val.push_back(0);
      push_string("2 Feb 2020 1:2:3"); override_q.push_back(0); override_val.push_back(0);
      wait_results();

      // long receiver hold-off while the sender keeps offering
      hold_off = 1;
      for (int i = 0; i < 12; i++) begin
         push_string(random_date());
         override_q.push_back(0); override_val.push_back(0);
      end
      wait (hold_left != 0);
      hold_off = 0;
      wait_results();

      // random phases: different idling and register settings
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 34 : (phase == 1) ? 85 : 0;
         receiver_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 34 : 0;
         write_local($urandom_range(0, 2880) - 1440);
         while (sent < 200 * (phase + 1)) begin
            s = random_date();
            if ($urandom_range(9) == 0) s = noise_text($urandom_range(1, 3));
            sent += s.len();
            push_string(s);
            override_q.push_back(0); override_val.push_back(0);
         end
         wait_results();
      end

      if (!failed) $display("date_string_to_epoch_parser test passed");
      else $display("date_string_to_epoch_parser test failed");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/dsep_pkg.sv
hw/rtl/dsep_front.sv
hw/rtl/dsep_back.sv
hw/rtl/date_string_to_epoch_parser.sv
tb/sv/tb.sv
